// ===== sv/mqbt_pkg.sv =====
// Shared types, constants and codes of the multi-queue barrier tracker.
package mqbt_pkg;

    localparam int QUEUES  = 64;
    localparam int IDX_W   = $clog2(QUEUES);
    localparam int TOT_W   = $clog2(QUEUES + 1);
    localparam int QID_W   = 6;
    localparam int CNT_W   = 16;
    localparam int ENTRY_W = CNT_W + 2;

    localparam logic [1:0] MODE_ARM    = 2'd0;
    localparam logic [1:0] MODE_ENQ    = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;
    localparam logic [1:0] MODE_COMPL  = 2'd3;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             valid;
        logic             sent;
    } entry_t;

    typedef struct packed {
        logic [1:0]       mode;
        logic             in_range;
        logic [CNT_W-1:0] count;
        logic             last;
    } item_t;

    typedef struct packed {
        logic insert_barrier;
        logic found;
        logic finished;
        logic barrier_done;
    } result_t;

    typedef struct packed {
        logic             we;
        entry_t           wentry;
        logic [TOT_W-1:0] total;
        logic             active;
        result_t          res;
    } update_t;

endpackage

// ===== sv/multi_queue_barrier_tracker_unit.sv =====
// Top level of the multi-queue barrier tracker: sequencer, table RAM and result register.
// Each transaction is a read-modify-write: the queue's table entry is read from the RAM in the
// cycle the transaction is accepted, then modified and written back in the next cycle, when
// the result is loaded into the output register. A new transaction is taken while that
// result waits only once it is being drained. After reset the block runs a clearing pass
// over all QUEUES (64) table entries, one entry per cycle, before in_ready first rises.
module multi_queue_barrier_tracker_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     mode,
    input  logic [mqbt_pkg::QID_W-1:0]     queue_id,
    input  logic [mqbt_pkg::CNT_W-1:0]     pending_count,
    input  logic                           last_entry,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           insert_barrier,
    output logic                           found,
    output logic                           finished,
    output logic                           barrier_done
);

    import mqbt_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] clr_reg, clr_next;
    logic [TOT_W-1:0] total_reg, total_next;
    logic             active_reg, active_next;
    logic             out_valid_reg, out_valid_next;
    result_t          res_reg;
    item_t            item_reg;
    logic [IDX_W-1:0] addr_reg;

    logic             accept;
    item_t            item_in;
    logic [IDX_W-1:0] addr_in;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    entry_t           ram_wdata;
    entry_t           ram_rdata;
    update_t          upd;

    assign addr_in          = IDX_W'(queue_id);
    assign item_in.mode     = mode;
    assign item_in.in_range = (32'(queue_id) < 32'(QUEUES));
    assign item_in.count    = pending_count;
    assign item_in.last     = last_entry;

    assign in_ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    mqbt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (addr_in),
        .rdata (ram_rdata)
    );

    mqbt_update u_update (
        .item   (item_reg),
        .entry  (ram_rdata),
        .total  (total_reg),
        .active (active_reg),
        .upd    (upd)
    );

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        total_next     = total_reg;
        active_next    = active_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ram_we         = 1'b0;
        ram_waddr      = addr_reg;
        ram_wdata      = upd.wentry;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + IDX_W'(1);
                if (clr_reg == IDX_W'(QUEUES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                // write back the entry and publish the result
                ram_we         = upd.we;
                total_next     = upd.total;
                active_next    = upd.active;
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            total_reg     <= '0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            total_reg     <= total_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_in;
            addr_reg <= addr_in;
        end
        if (state_reg == ST_READ)
        begin
            res_reg <= upd.res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign insert_barrier = res_reg.insert_barrier;
    assign found          = res_reg.found;
    assign finished       = res_reg.finished;
    assign barrier_done   = res_reg.barrier_done;

endmodule

// ===== sv/mqbt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module mqbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/mqbt_update.sv =====
// Read-modify-write logic for one table entry and the barrier state.
module mqbt_update (
    input  mqbt_pkg::item_t               item,
    input  mqbt_pkg::entry_t              entry,
    input  logic [mqbt_pkg::TOT_W-1:0]    total,
    input  logic                          active,
    output mqbt_pkg::update_t             upd
);

    import mqbt_pkg::*;

    logic [CNT_W-1:0] dec_count;
    logic [TOT_W-1:0] dec_total;

    assign dec_count = entry.count - CNT_W'(1);
    assign dec_total = (total != '0) ? total - TOT_W'(1) : total;

    always_comb
    begin
        upd        = '0;
        upd.wentry = entry;
        upd.total  = total;
        upd.active = active;
        case (item.mode)
            MODE_ARM:
            begin
                upd.active = 1'b1;
                if (item.in_range && item.count != '0)
                begin
                    upd.we           = 1'b1;
                    upd.wentry.count = item.count;
                    upd.wentry.valid = 1'b1;
                    if (!entry.valid)
                    begin
                        upd.total = total + TOT_W'(1);
                    end
                end
                // last entry of a snapshot with nothing outstanding clears at once
                if (item.last && upd.total == '0)
                begin
                    upd.active       = 1'b0;
                    upd.res.finished = 1'b1;
                end
            end
            MODE_ENQ:
            begin
                if (item.in_range && active && !entry.sent)
                begin
                    upd.we                 = 1'b1;
                    upd.wentry.sent        = 1'b1;
                    upd.res.insert_barrier = 1'b1;
                end
            end
            MODE_REMOVE:
            begin
                if (item.in_range && entry.valid)
                begin
                    upd.we           = 1'b1;
                    upd.wentry.valid = 1'b0;
                    upd.total        = dec_total;
                    if (dec_total == '0 && active)
                    begin
                        upd.active       = 1'b0;
                        upd.res.finished = 1'b1;
                    end
                end
            end
            default:
            begin
                if (item.in_range && entry.valid)
                begin
                    upd.we           = 1'b1;
                    upd.res.found    = 1'b1;
                    upd.wentry.count = dec_count;
                    if (dec_count == '0)
                    begin
                        upd.wentry.valid = 1'b0;
                        upd.total        = dec_total;
                        if (dec_total == '0 && active)
                        begin
                            upd.active       = 1'b0;
                            upd.res.finished = 1'b1;
                        end
                    end
                end
            end
        endcase
        upd.res.barrier_done = !upd.active;
    end

endmodule

// ===== sv/mqbt_checker.sv =====
// Port-level assertions for the multi-queue barrier tracker, bound to the top level.
module mqbt_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic [1:0]                 mode,
    input logic [mqbt_pkg::QID_W-1:0] queue_id,
    input logic [mqbt_pkg::CNT_W-1:0] pending_count,
    input logic                       last_entry,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic                       insert_barrier,
    input logic                       found,
    input logic                       finished,
    input logic                       barrier_done
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(insert_barrier) && $stable(found)
            && $stable(finished) && $stable(barrier_done))
        else $error("stalled result changed");

    // one transaction in flight: no accept straight after an accept
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second transaction accepted while one is in flight");

    // a stalled result blocks the input
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input accepted while result is stalled");

    a_finished_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && finished |-> barrier_done && !insert_barrier)
        else $error("finished without the barrier cleared");

    a_insert_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && insert_barrier |-> !found && !barrier_done)
        else $error("insert reported with an inactive barrier or a match");

endmodule

bind multi_queue_barrier_tracker_unit mqbt_checker u_mqbt_checker (.*);

// ===== tb/sv/testbench.sv =====
// Testbench of the multi-queue barrier tracker: stimulus, tracker prediction and result checks.
`timescale 1ns / 100ps

module testbench;
    import mqbt_pkg::*;

    localparam int N_ITEMS     = 1550;
    localparam int STALL_LIMIT = 2000;
    localparam int CALM_FROM   = 900;
    localparam int CALM_TO     = 1150;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_LEN    = 150;

    typedef struct {
        logic [1:0]       mode;
        logic [QID_W-1:0] qid;
        logic [CNT_W-1:0] cnt;
        logic             last;
        bit               drain_first;
    } queue_op_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    logic [1:0]       mode = MODE_ARM;
    logic [QID_W-1:0] queue_id = '0;
    logic [CNT_W-1:0] pending_count = '0;
    logic             last_entry = 1'b0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic             insert_barrier;
    logic             found;
    logic             finished;
    logic             barrier_done;

    queue_op_t        queued_ops[$];
    result_t          expected_results[$];
    logic             in_taken = 1'b0;
    int               n_in = 0;
    int               n_out = 0;
    int               n_err = 0;

    // tracker state as the testbench sees it
    logic [CNT_W-1:0] q_count[QUEUES];
    bit               q_waiting[QUEUES];
    bit               q_told[QUEUES];
    logic [TOT_W-1:0] n_waiting = '0;
    bit               armed = 1'b0;

    multi_queue_barrier_tracker_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .queue_id       (queue_id),
        .pending_count  (pending_count),
        .last_entry     (last_entry),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .insert_barrier (insert_barrier),
        .found          (found),
        .finished       (finished),
        .barrier_done   (barrier_done)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    task automatic add_op(input logic [1:0] m, input logic [QID_W-1:0] q,
                          input logic [CNT_W-1:0] c, input logic l);
        queue_op_t op;
        op.mode = m;
        op.qid = q;
        op.cnt = c;
        op.last = l;
        op.drain_first = (queued_ops.size() % 500 == 499);
        queued_ops.push_back(op);
    endtask

    task automatic report_mismatch(input string field, input logic got, input logic want);
        $display("result %0d: %s is %b, expected %b", n_out, field, got, want);
        n_err++;
    endtask

    // Drop a waiting queue; return 1 when that clears an active barrier.
    function automatic bit drop_queue(input int q);
        q_waiting[q] = 1'b0;
        if (n_waiting != 0)
            n_waiting--;
        if (n_waiting == 0 && armed)
        begin
            armed = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic result_t advance_tracker(input logic [1:0] m, input logic [QID_W-1:0] qid,
                                                input logic [CNT_W-1:0] c, input logic l);
        result_t r;
        int      q;
        bit      ok;
        r = '0;
        q = int'(qid);
        ok = q < QUEUES;
        case (m)
            MODE_ARM:
            begin
                armed = 1'b1;
                if (ok && c != 0)
                begin
                    q_count[q] = c;
                    if (!q_waiting[q])
                    begin
                        q_waiting[q] = 1'b1;
                        n_waiting++;
                    end
                end
                if (l && n_waiting == 0)
                begin
                    armed = 1'b0;
                    r.finished = 1'b1;
                end
            end
            MODE_ENQ:
            begin
                if (ok && armed && !q_told[q])
                begin
                    q_told[q] = 1'b1;
                    r.insert_barrier = 1'b1;
                end
            end
            MODE_REMOVE:
            begin
                if (ok && q_waiting[q])
                    r.finished = drop_queue(q);
            end
            default:
            begin
                if (ok && q_waiting[q])
                begin
                    r.found = 1'b1;
                    q_count[q] = q_count[q] - 1'b1;
                    if (q_count[q] == 0)
                        r.finished = drop_queue(q);
                end
            end
        endcase
        r.barrier_done = !armed;
        return r;
    endfunction

    // Driver: offer the next operation at the falling edge, hold until taken.
    always @(negedge clk)
    begin
        bit        offer;
        queue_op_t op;
        if (rst_n && !(in_valid && !in_taken))
        begin
            offer = queued_ops.size() != 0;
            if (offer && queued_ops[0].drain_first && expected_results.size() != 0)
                offer = 1'b0;
            if (offer && !(n_in >= CALM_FROM && n_in < CALM_TO) && $urandom_range(0, 99) < 17)
                offer = 1'b0;
            if (offer)
            begin
                op = queued_ops.pop_front();
                mode <= op.mode;
                queue_id <= op.qid;
                pending_count <= op.cnt;
                last_entry <= op.last;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: random back-pressure plus one long hold-off.
    int hold_left = 0;
    bit hold_done = 1'b0;
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (!hold_done && n_out >= HOLD_AT)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_LEN;
            out_ready <= 1'b0;
        end
        else
            out_ready <= (n_in >= CALM_FROM && n_in < CALM_TO) || $urandom_range(0, 99) >= 17;
    end

    // Monitor: predict on each input transaction, check each output transaction.
    always @(posedge clk)
    begin
        result_t want;
        in_taken <= in_valid && in_ready;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                expected_results.push_back(
                    advance_tracker(mode, queue_id, pending_count, last_entry));
                n_in++;
            end
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("result %0d arrived with nothing outstanding", n_out);
                    n_err++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (insert_barrier !== want.insert_barrier)
                        report_mismatch("insert_barrier", insert_barrier, want.insert_barrier);
                    if (found !== want.found)
                        report_mismatch("found", found, want.found);
                    if (finished !== want.finished)
                        report_mismatch("finished", finished, want.finished);
                    if (barrier_done !== want.barrier_done)
                        report_mismatch("barrier_done", barrier_done, want.barrier_done);
                end
                n_out++;
            end
        end
    end

    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("no transaction for %0d cycles", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        queue_op_t        steps[$];
        queue_op_t        tmp;
        logic [QID_W-1:0] round_ids[$];
        logic [CNT_W-1:0] round_cnt[QUEUES];
        logic [QID_W-1:0] qid;
        logic [CNT_W-1:0] cnt;
        logic [1:0]       m;
        int               n_q;
        int               r;
        int               j;
        int               total_ops;

        for (int i = 0; i < QUEUES; i++)
        begin
            q_count[i] = '0;
            q_waiting[i] = 1'b0;
            q_told[i] = 1'b0;
            round_cnt[i] = '0;
        end

        // idle table: nothing to find, remove or tell
        add_op(MODE_COMPL, 6'd5, 16'd0, 1'b0);
        add_op(MODE_REMOVE, 6'd7, 16'd0, 1'b0);
        add_op(MODE_ENQ, 6'd3, 16'd0, 1'b0);
        // zero count still arms; last entry with no queue waiting clears at once
        add_op(MODE_ARM, 6'd0, 16'd0, 1'b0);
        add_op(MODE_ARM, 6'd63, 16'd0, 1'b1);
        add_op(MODE_ARM, 6'd1, 16'hFFFF, 1'b0);
        add_op(MODE_ARM, 6'd2, 16'd2, 1'b0);
        add_op(MODE_ARM, 6'd2, 16'd1, 1'b0);
        add_op(MODE_ARM, 6'd62, 16'd1, 1'b1);
        // a queue is told only once
        add_op(MODE_ENQ, 6'd1, 16'd0, 1'b0);
        add_op(MODE_ENQ, 6'd1, 16'd0, 1'b0);
        add_op(MODE_ENQ, 6'd62, 16'd0, 1'b0);
        add_op(MODE_COMPL, 6'd2, 16'd0, 1'b0);
        add_op(MODE_COMPL, 6'd2, 16'd0, 1'b0);
        add_op(MODE_REMOVE, 6'd1, 16'd0, 1'b0);
        add_op(MODE_COMPL, 6'd62, 16'd0, 1'b0);
        add_op(MODE_ENQ, 6'd0, 16'd0, 1'b0);
        add_op(MODE_ARM, 6'd3, 16'd3, 1'b1);
        add_op(MODE_REMOVE, 6'd3, 16'd0, 1'b0);

        while (queued_ops.size() < N_ITEMS)
        begin
            if ($urandom_range(0, 99) < 82)
            begin
                // one snapshot: arm entries, then shuffled enqueues, completions and removes
                n_q = $urandom_range(1, 6);
                round_ids.delete();
                for (int i = 0; i < n_q; i++)
                begin
                    qid = QID_W'($urandom_range(0, QUEUES - 1));
                    r = $urandom_range(0, 99);
                    cnt = (r < 8) ? 16'($urandom) : (r < 14) ? 16'd0 : 16'($urandom_range(1, 4));
                    add_op(MODE_ARM, qid, cnt, i == n_q - 1);
                    round_ids.push_back(qid);
                    if (cnt != 0)
                        round_cnt[qid] = cnt;
                end
                steps.delete();
                foreach (round_ids[i])
                begin
                    qid = round_ids[i];
                    tmp.qid = qid;
                    tmp.cnt = 16'($urandom);
                    tmp.last = 1'($urandom_range(0, 1));
                    tmp.drain_first = 1'b0;
                    tmp.mode = MODE_ENQ;
                    steps.push_back(tmp);
                    if (round_cnt[qid] > 8 || (round_cnt[qid] != 0 && $urandom_range(0, 99) < 15))
                    begin
                        tmp.mode = MODE_REMOVE;
                        steps.push_back(tmp);
                    end
                    else
                    begin
                        tmp.mode = MODE_COMPL;
                        for (int k = 0; k < int'(round_cnt[qid]); k++)
                            steps.push_back(tmp);
                    end
                    round_cnt[qid] = '0;
                end
                for (int i = steps.size() - 1; i > 0; i--)
                begin
                    j = $urandom_range(0, i);
                    tmp = steps[i];
                    steps[i] = steps[j];
                    steps[j] = tmp;
                end
                foreach (steps[i])
                begin
                    if ($urandom_range(0, 99) < 5)
                        add_op(MODE_COMPL, 6'($urandom), 16'($urandom), 1'($urandom_range(0, 1)));
                    add_op(steps[i].mode, steps[i].qid, steps[i].cnt, steps[i].last);
                end
            end
            else
            begin
                // noise; drop any queue that it arms so later snapshots can still clear
                n_q = $urandom_range(1, 4);
                for (int i = 0; i < n_q; i++)
                begin
                    m = 2'($urandom_range(0, 3));
                    qid = QID_W'($urandom_range(0, QUEUES - 1));
                    add_op(m, qid, 16'($urandom), 1'($urandom_range(0, 1)));
                    if (m == MODE_ARM)
                        add_op(MODE_REMOVE, qid, 16'($urandom), 1'($urandom_range(0, 1)));
                end
            end
        end
        total_ops = queued_ops.size();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (n_in < total_ops)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (n_err == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
